[src/npm_pkg.sv]
// shared constants, register codes and curve table builder for the palette mapper
package npm_pkg;

  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_CURVE_BITS  = 10;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned PALETTE_W  = 4;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned WEIGHT_W   = 17;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PALETTE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HA_GAIN     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OIII_GAIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SII_GAIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HA_PRESENT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SII_PRESENT = 3'd5;

  // palette codes
  localparam logic [PALETTE_W-1:0] PAL_SHO       = 4'd0;
  localparam logic [PALETTE_W-1:0] PAL_HOO       = 4'd1;
  localparam logic [PALETTE_W-1:0] PAL_HSO       = 4'd2;
  localparam logic [PALETTE_W-1:0] PAL_HOS       = 4'd3;
  localparam logic [PALETTE_W-1:0] PAL_OSS       = 4'd4;
  localparam logic [PALETTE_W-1:0] PAL_OHH       = 4'd5;
  localparam logic [PALETTE_W-1:0] PAL_OSH       = 4'd6;
  localparam logic [PALETTE_W-1:0] PAL_OHS       = 4'd7;
  localparam logic [PALETTE_W-1:0] PAL_HSS       = 4'd8;
  localparam logic [PALETTE_W-1:0] PAL_NONLINEAR = 4'd9;
  localparam logic [PALETTE_W-1:0] PAL_BLEND1    = 4'd10;
  localparam logic [PALETTE_W-1:0] PAL_BLEND2    = 4'd11;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;
  localparam int unsigned GAIN_FRAC = 12;

  // blend weights, q1.16 with unity as 65536
  localparam logic [WEIGHT_W-1:0] BLEND_W_ONE  = 17'd65536;
  localparam logic [WEIGHT_W-1:0] BLEND_W_HALF = 17'd32768;
  localparam logic [WEIGHT_W-1:0] BLEND_W_0P3  = 17'd19661;
  localparam logic [WEIGHT_W-1:0] BLEND_W_0P7  = 17'd45875;
  localparam logic [WEIGHT_W-1:0] BLEND_W_0P9  = 17'd58982;
  localparam int unsigned BLEND_ROUND = 32768;

  localparam logic [63:0] Q30     = 64'd1 << 30;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // log2 of k in q.16 by repeated squaring
  function automatic logic [63:0] log2_q16(logic [63:0] k);
    logic [63:0] p;
    logic [63:0] m;
    logic [63:0] bits;
    p    = '0;
    bits = '0;
    for (int i = 0; i < 31; i++) begin
      if (p < 64'd31 && (k >> (p + 64'd1)) != 64'd0) begin
        p = p + 64'd1;
      end
    end
    m = k << (64'd30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (Q30 << 1)) begin
        m    = m >> 1;
        bits = bits | (64'd1 << (15 - i));
      end
    end
    return (p << 16) | bits;
  endfunction

  // 2^(f/65536) in q2.30, series of e^y
  function automatic logic [63:0] exp2_frac_q30(logic [63:0] f);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    y    = (f * LN2_Q30) >> 16;
    sum  = Q30;
    term = Q30;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * y) >> 30) / 64'(n);
      sum  = sum + term;
    end
    return sum;
  endfunction

  // one entry of the x^(1-x) curve, q1.16, for a table of 2^t + 1 entries
  function automatic logic [WEIGHT_W-1:0] curve_entry(int unsigned k, int unsigned t);
    logic [63:0] neg;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] val;
    logic [63:0] sh;
    if (k == 0) begin
      return '0;
    end
    neg = (64'(t) << 16) - log2_q16(64'(k));
    mag = (neg * ((64'd1 << t) - 64'(k))) >> t;
    q   = mag >> 16;
    r   = mag & 64'hFFFF;
    if (r == 64'd0) begin
      val = Q30;
      sh  = q;
    end else begin
      val = exp2_frac_q30(64'd65536 - r);
      sh  = q + 64'd1;
    end
    val = (sh >= 64'd62) ? 64'd0 : (val >> sh);
    return WEIGHT_W'((val + (64'd1 << 13)) >> 14);
  endfunction

endpackage

[src/npm_ram.sv]
// generic single-write ram with registered read
module npm_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/npm_blend.sv]
// two-stage weighted mix of two samples: (w*a + (1-w)*b) rounded
module npm_blend import npm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic [WEIGHT_W-1:0]    weight_i,
  input  logic [SAMPLE_BITS-1:0] op_a_i,
  input  logic [SAMPLE_BITS-1:0] op_b_i,
  output logic [SAMPLE_BITS-1:0] mix_o
);

  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned PROD_W = S + WEIGHT_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  logic [WEIGHT_W-1:0] weight_b;
  logic [PROD_W-1:0]   prod_a_d, prod_b_d;
  logic [PROD_W-1:0]   prod_a_q, prod_b_q;
  logic [SUM_W-1:0]    sum;
  logic [S-1:0]        mix_d, mix_q;

  always_comb begin
    weight_b = BLEND_W_ONE - weight_i;
    prod_a_d = PROD_W'(weight_i) * PROD_W'(op_a_i);
    prod_b_d = PROD_W'(weight_b) * PROD_W'(op_b_i);
  end

  // the mix never exceeds full scale, so the top bits are always clear
  always_comb begin
    sum   = SUM_W'(prod_a_q) + SUM_W'(prod_b_q) + SUM_W'(BLEND_ROUND);
    mix_d = sum[S+15:16];
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    mix_q    <= mix_d;
  end

  assign mix_o = mix_q;

endmodule

[src/narrowband_palette_mapper.sv]
// narrowband palette mapper top level: gain, substitution, palette and curve blend
//
//  channel  | direction | signals                                   | handshake
//  ---------+-----------+-------------------------------------------+---------------------------
//  pixel in | in        | ha_sample_i, oiii_sample_i, sii_sample_i  | start high, busy low
//  rgb out  | out       | red_o, green_o, blue_o                    | result_valid_o, one cycle
//  config   | in/out    | psel, penable, pwrite, paddr, pwdata, ... | apb, pready tied high
//
// one item per clock while busy is low; the result strobe is high in the same cycle as the
// result on red_o, green_o and blue_o, and each item passes eight register stages (input,
// gain multiply, saturate, product, index, curve ram, blend multiply, blend sum).
// after reset busy stays high while all 2^CURVE_TABLE_BITS + 1 entries of the curve ram
// are loaded one entry a cycle; busy never rises again after that.
// the pipeline never stalls: the receiver takes every result as it appears.
module narrowband_palette_mapper import npm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS      = DEF_SAMPLE_BITS,
  parameter int unsigned CURVE_TABLE_BITS = DEF_CURVE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] ha_sample_i,
  input  logic [SAMPLE_BITS-1:0] oiii_sample_i,
  input  logic [SAMPLE_BITS-1:0] sii_sample_i,
  output logic                   result_valid_o,
  output logic [SAMPLE_BITS-1:0] red_o,
  output logic [SAMPLE_BITS-1:0] green_o,
  output logic [SAMPLE_BITS-1:0] blue_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int unsigned S          = SAMPLE_BITS;
  localparam int unsigned T          = CURVE_TABLE_BITS;
  localparam int unsigned CURVE_SIZE = (1 << T) + 1;
  localparam int unsigned IDX_W      = T + 1;
  localparam int unsigned PROD_W     = S + GAIN_W;
  localparam int unsigned STAGES     = 8;

  typedef logic [WEIGHT_W-1:0] curve_rom_t [CURVE_SIZE];

  typedef struct packed {
    logic                use_curve;
    logic [WEIGHT_W-1:0] weight;
    logic [S-1:0]        op_a;
    logic [S-1:0]        op_b;
  } chan_t;

  function automatic curve_rom_t build_curve_rom();
    curve_rom_t rom;
    for (int k = 0; k < CURVE_SIZE; k++) begin
      rom[k] = curve_entry(k, T);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve_rom();

  // gain product rounded to q0.S and clipped at full scale
  function automatic logic [S-1:0] scale_sat(logic [PROD_W-1:0] prod);
    logic [PROD_W:0]    rnd;
    logic [PROD_W-12:0] shr;
    rnd = {1'b0, prod} + (PROD_W+1)'(1 << (GAIN_FRAC - 1));
    shr = rnd[PROD_W:GAIN_FRAC];
    return (|shr[PROD_W-12:S]) ? {S{1'b1}} : shr[S-1:0];
  endfunction

  // nearest curve entry for a q0.S value
  function automatic logic [IDX_W-1:0] curve_idx(logic [S-1:0] x);
    logic [S+T:0] sum;
    sum = {1'b0, x, {T{1'b0}}} + ((S+T+1)'(1) << (S - 1));
    return sum[S+T:S];
  endfunction

  function automatic chan_t pass(logic [S-1:0] x);
    return '{use_curve: 1'b0, weight: BLEND_W_ONE, op_a: x, op_b: x};
  endfunction

  function automatic chan_t mix(logic [WEIGHT_W-1:0] w, logic [S-1:0] a, logic [S-1:0] b);
    return '{use_curve: 1'b0, weight: w, op_a: a, op_b: b};
  endfunction

  function automatic chan_t curved(logic [S-1:0] a, logic [S-1:0] b);
    return '{use_curve: 1'b1, weight: BLEND_W_ONE, op_a: a, op_b: b};
  endfunction

  // ---------------------------------------------------------------- config port
  logic [PALETTE_W-1:0] palette_q;
  logic [GAIN_W-1:0]    ha_gain_q, oiii_gain_q, sii_gain_q;
  logic                 ha_present_q, sii_present_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q     <= PAL_SHO;
      ha_gain_q     <= GAIN_UNITY;
      oiii_gain_q   <= GAIN_UNITY;
      sii_gain_q    <= GAIN_UNITY;
      ha_present_q  <= 1'b1;
      sii_present_q <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PALETTE:     palette_q     <= pwdata[PALETTE_W-1:0];
        REG_HA_GAIN:     ha_gain_q     <= pwdata[GAIN_W-1:0];
        REG_OIII_GAIN:   oiii_gain_q   <= pwdata[GAIN_W-1:0];
        REG_SII_GAIN:    sii_gain_q    <= pwdata[GAIN_W-1:0];
        REG_HA_PRESENT:  ha_present_q  <= pwdata[0];
        REG_SII_PRESENT: sii_present_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PALETTE:     prdata = APB_DATA_W'(palette_q);
      REG_HA_GAIN:     prdata = APB_DATA_W'(ha_gain_q);
      REG_OIII_GAIN:   prdata = APB_DATA_W'(oiii_gain_q);
      REG_SII_GAIN:    prdata = APB_DATA_W'(sii_gain_q);
      REG_HA_PRESENT:  prdata = APB_DATA_W'(ha_present_q);
      REG_SII_PRESENT: prdata = APB_DATA_W'(sii_present_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- curve ram load
  logic             filling_q;
  logic [IDX_W-1:0] fill_addr_q;
  logic             item_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q   <= 1'b1;
      fill_addr_q <= '0;
    end else if (filling_q) begin
      if (fill_addr_q == IDX_W'(CURVE_SIZE - 1)) begin
        filling_q <= 1'b0;
      end else begin
        fill_addr_q <= fill_addr_q + IDX_W'(1);
      end
    end
  end

  assign busy        = filling_q;
  assign item_accept = start & ~filling_q;

  // ---------------------------------------------------------------- valid line
  logic [STAGES-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[STAGES-2:0], item_accept};
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [S-1:0]      ha1_q, oiii1_q, sii1_q;
  logic [PROD_W-1:0] prod_h_q, prod_o_q, prod_s_q;
  logic [S-1:0]      h_d, o_d, s_d, h3_q, o3_q, s3_q;
  logic [2*S-1:0]    ho4_q;
  logic [IDX_W-1:0]  idx_r4_q, idx_r5_q;
  chan_t             red_d, green_d, blue_d;
  chan_t             red4_q, green4_q, blue4_q;
  chan_t             red5_q, green5_q, blue5_q;
  chan_t             red6_q, green6_q, blue6_q;
  logic [2*S:0]      ho_rnd;
  logic [S-1:0]      p5_d, p5_q;
  logic [S-1:0]      o_floor;
  logic [IDX_W-1:0]  addr_g;
  logic [WEIGHT_W-1:0] curve_r, curve_g;
  logic [WEIGHT_W-1:0] w_red, w_green, w_blue;

  always_comb begin
    h_d = scale_sat(prod_h_q);
    o_d = scale_sat(prod_o_q);
    s_d = scale_sat(prod_s_q);
    // an absent channel borrows the other one, unless both are absent
    if (!ha_present_q && sii_present_q) begin
      h_d = s_d;
    end else if (!sii_present_q && ha_present_q) begin
      s_d = h_d;
    end
  end

  always_comb begin
    red_d   = pass(s3_q);
    green_d = pass(h3_q);
    blue_d  = pass(o3_q);
    case (palette_q)
      PAL_SHO: ;
      PAL_HOO: begin red_d = pass(h3_q); green_d = pass(o3_q); blue_d = pass(o3_q); end
      PAL_HSO: begin red_d = pass(h3_q); green_d = pass(s3_q); blue_d = pass(o3_q); end
      PAL_HOS: begin red_d = pass(h3_q); green_d = pass(o3_q); blue_d = pass(s3_q); end
      PAL_OSS: begin red_d = pass(o3_q); green_d = pass(s3_q); blue_d = pass(s3_q); end
      PAL_OHH: begin red_d = pass(o3_q); green_d = pass(h3_q); blue_d = pass(h3_q); end
      PAL_OSH: begin red_d = pass(o3_q); green_d = pass(s3_q); blue_d = pass(h3_q); end
      PAL_OHS: begin red_d = pass(o3_q); green_d = pass(h3_q); blue_d = pass(s3_q); end
      PAL_HSS: begin red_d = pass(h3_q); green_d = pass(s3_q); blue_d = pass(s3_q); end
      PAL_NONLINEAR: begin
        red_d   = curved(s3_q, h3_q);
        green_d = curved(h3_q, o3_q);
        blue_d  = pass(o3_q);
      end
      PAL_BLEND1: begin
        red_d   = mix(BLEND_W_HALF, h3_q, s3_q);
        green_d = mix(BLEND_W_0P3, h3_q, o3_q);
        blue_d  = mix(BLEND_W_0P9, o3_q, h3_q);
      end
      PAL_BLEND2: begin
        red_d   = mix(BLEND_W_0P7, h3_q, s3_q);
        green_d = mix(BLEND_W_0P3, s3_q, o3_q);
        blue_d  = pass(o3_q);
      end
      default: ;
    endcase
  end

  // red term floors oiii at one lsb, green product does not
  assign o_floor = (o3_q == '0) ? S'(1) : o3_q;

  always_comb begin
    ho_rnd = {1'b0, ho4_q} + ((2*S+1)'(1) << (S - 1));
    p5_d   = ho_rnd[2*S-1:S];
  end

  assign addr_g = curve_idx(p5_q);

  always_ff @(posedge clk_i) begin
    ha1_q    <= ha_sample_i;
    oiii1_q  <= oiii_sample_i;
    sii1_q   <= sii_sample_i;
    prod_h_q <= PROD_W'(ha1_q) * PROD_W'(ha_gain_q);
    prod_o_q <= PROD_W'(oiii1_q) * PROD_W'(oiii_gain_q);
    prod_s_q <= PROD_W'(sii1_q) * PROD_W'(sii_gain_q);
    h3_q     <= h_d;
    o3_q     <= o_d;
    s3_q     <= s_d;
    ho4_q    <= (2*S)'(h3_q) * (2*S)'(o3_q);
    idx_r4_q <= curve_idx(o_floor);
    red4_q   <= red_d;
    green4_q <= green_d;
    blue4_q  <= blue_d;
    p5_q     <= p5_d;
    idx_r5_q <= idx_r4_q;
    red5_q   <= red4_q;
    green5_q <= green4_q;
    blue5_q  <= blue4_q;
    red6_q   <= red5_q;
    green6_q <= green5_q;
    blue6_q  <= blue5_q;
  end

  npm_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (CURVE_SIZE)
  ) u_curve_red (
    .clk_i     (clk_i),
    .wr_en_i   (filling_q),
    .wr_addr_i (fill_addr_q),
    .wr_data_i (CURVE_ROM[fill_addr_q]),
    .rd_addr_i (idx_r5_q),
    .rd_data_o (curve_r)
  );

  npm_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (CURVE_SIZE)
  ) u_curve_green (
    .clk_i     (clk_i),
    .wr_en_i   (filling_q),
    .wr_addr_i (fill_addr_q),
    .wr_data_i (CURVE_ROM[fill_addr_q]),
    .rd_addr_i (addr_g),
    .rd_data_o (curve_g)
  );

  assign w_red   = red6_q.use_curve ? curve_r : red6_q.weight;
  assign w_green = green6_q.use_curve ? curve_g : green6_q.weight;
  assign w_blue  = blue6_q.weight;

  npm_blend #(.SAMPLE_BITS(S)) u_blend_red (
    .clk_i    (clk_i),
    .weight_i (w_red),
    .op_a_i   (red6_q.op_a),
    .op_b_i   (red6_q.op_b),
    .mix_o    (red_o)
  );

  npm_blend #(.SAMPLE_BITS(S)) u_blend_green (
    .clk_i    (clk_i),
    .weight_i (w_green),
    .op_a_i   (green6_q.op_a),
    .op_b_i   (green6_q.op_b),
    .mix_o    (green_o)
  );

  npm_blend #(.SAMPLE_BITS(S)) u_blend_blue (
    .clk_i    (clk_i),
    .weight_i (w_blue),
    .op_a_i   (blue6_q.op_a),
    .op_b_i   (blue6_q.op_b),
    .mix_o    (blue_o)
  );

  assign result_valid_o = valid_q[STAGES-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_accept |-> ##8 result_valid_o)
    else $error("accepted item did not reach the output on time");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(item_accept, 8))
    else $error("result strobe without a matching accepted item");

  a_load_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("curve ram load restarted");

  a_no_result_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !result_valid_o)
    else $error("result while curve ram still loading");

  a_green_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> addr_g <= IDX_W'(CURVE_SIZE - 1))
    else $error("curve address beyond table");
`endif

endmodule
